// ----- rtl/cbals_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbals_pkg
// Shared widths, codes and controller/datapath interface types of the
// cubic Bezier arc length sampler.
// ---------------------------------------------------------------------------
package cbals_pkg;

   localparam int COORD_W     = 32;
   localparam int T_W         = 17;
   localparam int DIST_W      = 32;
   localparam int NSUB_W      = 11;
   localparam int NUM_CSR     = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_LANE    = 2;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 96;

   localparam int MUL_W     = 33;
   localparam int PROD_W    = 66;
   localparam int LEN_W     = 33;
   localparam int SUM_W     = 44;
   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 33;
   localparam int SQ_IN_W   = 64;
   localparam int ROOT_W    = SQ_IN_W / 2;

   localparam int DEF_MAX_SUBDIVISIONS = 1024;

   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   // control point numbers; register index is 2 * point + lane
   localparam int PT_START  = 0;
   localparam int PT_GUIDE1 = 1;
   localparam int PT_GUIDE2 = 2;
   localparam int PT_FINISH = 3;

   localparam logic OP_PARAM = 1'b0;
   localparam logic OP_DIST  = 1'b1;

   typedef enum logic [2:0] {
      LERP_A,
      LERP_B,
      LERP_C,
      LERP_D,
      LERP_E,
      LERP_R,
      LERP_HIT
   } lerp_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NDIV_GO,
      S_NDIV_WAIT,
      S_TSTEP,
      S_LMUL,
      S_LWB,
      S_SQ,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_ACC,
      S_FDIV_GO,
      S_FDIV_WAIT,
      S_IMUL,
      S_IWB,
      S_ADV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic         accept;
      logic         div_n;
      logic         init;
      logic         t_step;
      logic         mul_lerp;
      logic         wb_lerp;
      lerp_sel_type lerp_sel;
      logic         sq;
      logic         root_start;
      logic         acc;
      logic         div_frac;
      logic         advance;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic op;
      logic div_done;
      logic root_done;
      logic hit_now;
      logic last;
   } dp_status_type;

endpackage

// ----- rtl/cbals_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbals_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
module cbals_div import cbals_pkg::*; #(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   sh;
   logic [DEN_W+1:0] trial;

   always_comb begin
      sh      = {rem_ff, quo_ff[NUM_W-1]};
      trial   = {1'b0, sh} - {2'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/cbals_sqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbals_sqrt
// Integer square root, one result bit per cycle, floor result.
// ---------------------------------------------------------------------------
module cbals_sqrt import cbals_pkg::*; #(
   parameter int IN_W = SQ_IN_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IN_W-1:0]   value,
   output logic              done,
   output logic [IN_W/2-1:0] root
);

   localparam int OUT_W = IN_W / 2;
   localparam int CNT_W = $clog2(OUT_W + 1);
   localparam int REM_W = OUT_W + 3;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IN_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [OUT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0] sh;
   logic [REM_W-1:0] trial;

   always_comb begin
      sh      = {rem_ff[REM_W-3:0], val_ff[IN_W-1:IN_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(OUT_W);
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[IN_W-3:0], 2'b00};
         if (sh >= trial) begin
            rem_in  = sh - trial;
            root_in = {root_ff[OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = sh;
            root_in = {root_ff[OUT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/cbals_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbals_dp
// Datapath: control point registers, x and y lerp lanes with one multiplier
// each, chord length root, running sum, step parameter and shared divider.
// ---------------------------------------------------------------------------
module cbals_dp import cbals_pkg::*; #(
   parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_W-1:0]     csr_wdata,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   logic signed [COORD_W-1:0] cfg_ff [NUM_CSR];

   logic              op_ff;
   logic [T_W-1:0]    t_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [NSUB_W-1:0] n_ff;
   logic [T_W-1:0]    q0_ff, q_ff;
   logic [NSUB_W-1:0] r0_ff, r_ff, i_ff;
   logic [SUM_W-1:0]  total_ff, prev_total_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              hit_ff;
   logic              scale_ff;

   logic [COORD_W-1:0] out_x_ff, out_y_ff, out_tot_ff;
   logic               out_past_ff;

   logic [T_W-1:0]    in_t, in_t_c;
   logic [NSUB_W-1:0] in_n, in_n_c;

   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den, div_rem;
   logic [SUM_W-1:0]     frac_diff;
   logic [T_W-1:0]       frac;

   logic              root_done;
   logic [ROOT_W-1:0] root;
   logic [LEN_W-1:0]  len_c;
   logic [SUM_W-1:0]  total_new;
   logic [NSUB_W:0]   r_sum;

   logic signed [PROD_W-1:0] prod_ff [NUM_LANE];
   logic [COORD_W-1:0]       abs_d [NUM_LANE];
   logic [COORD_W-1:0]       lane_out [NUM_LANE];
   logic                     scale_c;
   logic [SQ_IN_W-1:0]       sq_sum;

   // request decode with clamping
   always_comb begin
      in_t   = req_tdata[T_W-1:0];
      in_t_c = (in_t > T_ONE) ? T_ONE : in_t;
      in_n   = req_tdata[T_W+DIST_W+NSUB_W-1:T_W+DIST_W];
      if (in_n == '0) begin
         in_n_c = NSUB_W'(1);
      end else if (32'(in_n) > 32'(MAX_SUBDIVISIONS)) begin
         in_n_c = NSUB_W'(MAX_SUBDIVISIONS);
      end else begin
         in_n_c = in_n;
      end
   end

   // shared divider: step size 1/n, then hit fraction
   assign frac_diff = {{(SUM_W-DIST_W){1'b0}}, dist_ff} - prev_total_ff;
   assign div_start = cmd.div_n | cmd.div_frac;
   assign div_num   = cmd.div_n ? DIV_NUM_W'(T_ONE) : {frac_diff[LEN_W-1:0], 16'h0000};
   assign div_den   = cmd.div_n ? DIV_DEN_W'(n_ff) : len_ff;
   assign frac      = (len_ff == '0) ? '0 : div_quo[T_W-1:0];

   cbals_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign scale_c = abs_d[0][COORD_W-1] | abs_d[1][COORD_W-1];
   assign sq_sum  = {1'b0, 63'(prod_ff[0][61:0]) + 63'(prod_ff[1][61:0])};

   cbals_sqrt #(
      .IN_W (SQ_IN_W)
   ) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_start),
      .value (sq_sum),
      .done  (root_done),
      .root  (root)
   );

   assign len_c     = scale_ff ? {root, 1'b0} : {1'b0, root};
   assign total_new = total_ff + SUM_W'(len_c);
   assign r_sum     = {1'b0, r_ff} + {1'b0, r0_ff};

   for (genvar l = 0; l < NUM_LANE; l++) begin : g_lane
      localparam int IDX_P0 = 2 * PT_START + l;
      localparam int IDX_P1 = 2 * PT_GUIDE1 + l;
      localparam int IDX_P2 = 2 * PT_GUIDE2 + l;
      localparam int IDX_P3 = 2 * PT_FINISH + l;

      logic signed [COORD_W-1:0] w_ff [6];
      logic signed [COORD_W-1:0] prev_ff;
      logic signed [COORD_W-1:0] hit_pos_ff;
      logic signed [COORD_W-1:0] op_a, op_b;
      logic [T_W-1:0]            op_f;
      logic [MUL_W-1:0]          diff, dx, ndx;
      logic signed [MUL_W-1:0]   ma, mb;
      logic [COORD_W-2:0]        sh;
      logic signed [PROD_W-1:0]  rsum, rnd;
      logic [COORD_W-1:0]        res;

      always_comb begin
         unique case (cmd.lerp_sel)
            LERP_A: begin
               op_a = cfg_ff[IDX_P0];
               op_b = cfg_ff[IDX_P1];
            end
            LERP_B: begin
               op_a = cfg_ff[IDX_P1];
               op_b = cfg_ff[IDX_P2];
            end
            LERP_C: begin
               op_a = cfg_ff[IDX_P2];
               op_b = cfg_ff[IDX_P3];
            end
            LERP_D: begin
               op_a = w_ff[0];
               op_b = w_ff[1];
            end
            LERP_E: begin
               op_a = w_ff[1];
               op_b = w_ff[2];
            end
            LERP_R: begin
               op_a = w_ff[3];
               op_b = w_ff[4];
            end
            LERP_HIT: begin
               op_a = prev_ff;
               op_b = w_ff[5];
            end
            default: begin
               op_a = prev_ff;
               op_b = w_ff[5];
            end
         endcase
         op_f     = (cmd.lerp_sel == LERP_HIT) ? frac : t_ff;
         diff     = {op_b[COORD_W-1], op_b} - {op_a[COORD_W-1], op_a};
         dx       = {w_ff[5][COORD_W-1], w_ff[5]} - {prev_ff[COORD_W-1], prev_ff};
         ndx      = -dx;
         abs_d[l] = dx[MUL_W-1] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
         sh       = scale_c ? abs_d[l][COORD_W-1:1] : abs_d[l][COORD_W-2:0];
         if (cmd.sq) begin
            ma = {2'b00, sh};
            mb = {2'b00, sh};
         end else begin
            ma = diff;
            mb = {{(MUL_W-T_W){1'b0}}, op_f};
         end
         rsum = prod_ff[l] + PROD_W'(32768);
         rnd  = rsum >>> 16;
         res  = op_a + rnd[COORD_W-1:0];
         if (op_ff == OP_PARAM) begin
            lane_out[l] = w_ff[5];
         end else if (hit_ff) begin
            lane_out[l] = hit_pos_ff;
         end else begin
            lane_out[l] = cfg_ff[IDX_P3];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.mul_lerp || cmd.sq) begin
            prod_ff[l] <= ma * mb;
         end
         if (cmd.wb_lerp) begin
            if (cmd.lerp_sel == LERP_HIT) begin
               hit_pos_ff <= res;
            end else begin
               w_ff[cmd.lerp_sel] <= res;
            end
         end
         if (cmd.init) begin
            prev_ff <= cfg_ff[IDX_P0];
         end else if (cmd.advance) begin
            prev_ff <= w_ff[5];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CSR; k++) begin
            cfg_ff[k] <= '0;
         end
         hit_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
         if (cmd.init) begin
            hit_ff <= 1'b0;
         end else if (cmd.acc && status.hit_now) begin
            hit_ff <= 1'b1;
         end
      end
      if (cmd.accept) begin
         op_ff   <= req_tuser;
         t_ff    <= in_t_c;
         dist_ff <= req_tdata[T_W+DIST_W-1:T_W];
         n_ff    <= in_n_c;
      end
      if (cmd.init) begin
         q0_ff    <= div_quo[T_W-1:0];
         r0_ff    <= div_rem[NSUB_W-1:0];
         q_ff     <= '0;
         r_ff     <= '0;
         i_ff     <= '0;
         total_ff <= '0;
      end
      if (cmd.t_step) begin
         if (r_sum >= {1'b0, n_ff}) begin
            r_ff <= NSUB_W'(r_sum - {1'b0, n_ff});
            q_ff <= q_ff + q0_ff + 1'b1;
            t_ff <= q_ff + q0_ff + 1'b1;
         end else begin
            r_ff <= r_sum[NSUB_W-1:0];
            q_ff <= q_ff + q0_ff;
            t_ff <= q_ff + q0_ff;
         end
      end
      if (cmd.sq) begin
         scale_ff <= scale_c;
      end
      if (cmd.acc) begin
         prev_total_ff <= total_ff;
         total_ff      <= total_new;
         len_ff        <= len_c;
      end
      if (cmd.advance) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.out_load) begin
         out_x_ff <= lane_out[0];
         out_y_ff <= lane_out[1];
         if (op_ff == OP_PARAM) begin
            out_tot_ff  <= '0;
            out_past_ff <= 1'b0;
         end else begin
            out_tot_ff  <= (total_ff[SUM_W-1:COORD_W] != '0) ? '1 : total_ff[COORD_W-1:0];
            out_past_ff <= ~hit_ff;
         end
      end
   end

   assign status.op        = op_ff;
   assign status.div_done  = div_done;
   assign status.root_done = root_done;
   assign status.hit_now   = ~hit_ff && ({{(SUM_W-DIST_W){1'b0}}, dist_ff} <= total_new);
   assign status.last      = (i_ff == n_ff - 1'b1);

   assign rsp_tdata = {out_tot_ff, out_y_ff, out_x_ff};
   assign rsp_tuser = out_past_ff;

endmodule

// ----- rtl/cbals_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbals_ctrl
// Controller: sequences point evaluation, chord walk, hit interpolation and
// the result handshake.
// ---------------------------------------------------------------------------
module cbals_ctrl import cbals_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type    state_ff, state_in;
   lerp_sel_type lerp_ff, lerp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free;

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      lerp_in  = lerp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               lerp_in  = LERP_A;
               state_in = S_NDIV_GO;
            end
         end
         S_NDIV_GO:   state_in = S_NDIV_WAIT;
         S_NDIV_WAIT: begin
            if (status.div_done) begin
               state_in = (status.op == OP_PARAM) ? S_LMUL : S_TSTEP;
            end
         end
         S_TSTEP: begin
            lerp_in  = LERP_A;
            state_in = S_LMUL;
         end
         S_LMUL:      state_in = S_LWB;
         S_LWB: begin
            if (lerp_ff == LERP_R) begin
               state_in = (status.op == OP_PARAM) ? S_DONE : S_SQ;
            end else begin
               lerp_in  = lerp_sel_type'(lerp_ff + 1'b1);
               state_in = S_LMUL;
            end
         end
         S_SQ:        state_in = S_ROOT_GO;
         S_ROOT_GO:   state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: begin
            if (status.root_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC:       state_in = status.hit_now ? S_FDIV_GO : S_ADV;
         S_FDIV_GO:   state_in = S_FDIV_WAIT;
         S_FDIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_IMUL;
            end
         end
         S_IMUL:      state_in = S_IWB;
         S_IWB:       state_in = S_ADV;
         S_ADV:       state_in = status.last ? S_DONE : S_TSTEP;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.lerp_sel   = lerp_ff;
      unique case (state_ff)
         S_IDLE:      cmd.accept     = req_tvalid;
         S_NDIV_GO:   cmd.div_n      = 1'b1;
         S_NDIV_WAIT: cmd.init       = status.div_done;
         S_TSTEP:     cmd.t_step     = 1'b1;
         S_LMUL:      cmd.mul_lerp   = 1'b1;
         S_LWB:       cmd.wb_lerp    = 1'b1;
         S_SQ:        cmd.sq         = 1'b1;
         S_ROOT_GO:   cmd.root_start = 1'b1;
         S_ROOT_WAIT: cmd.acc        = 1'b0;
         S_ACC:       cmd.acc        = 1'b1;
         S_FDIV_GO:   cmd.div_frac   = 1'b1;
         S_FDIV_WAIT: cmd.acc        = 1'b0;
         S_IMUL: begin
            cmd.lerp_sel = LERP_HIT;
            cmd.mul_lerp = 1'b1;
         end
         S_IWB: begin
            cmd.lerp_sel = LERP_HIT;
            cmd.wb_lerp  = 1'b1;
         end
         S_ADV:       cmd.advance    = 1'b1;
         S_DONE:      cmd.out_load   = out_free;
         default:     cmd.accept     = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lerp_ff      <= LERP_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lerp_ff      <= lerp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/cubic_bezier_arc_length_sampler_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_bezier_arc_length_sampler_unit
// Evaluates a 2D cubic Bezier curve at a parameter, or at an arc distance
// found by summing n chord lengths, with control points in registers.
// ---------------------------------------------------------------------------
// One word at a time. Both ops start with the accept and the serial divide
// that sets the step size. Op 0 (parameter) then runs six x/y lerp pairs on
// the two lane multipliers. Op 1 (distance) walks n chords for n
// subdivisions, plus a hit interpolation once for the chord where the
// distance is reached: each chord costs a step update, a point evaluation, a
// square and a bit-serial square root, and the hit fraction uses the serial
// divider again. A new word is taken as soon as the previous result is in
// the output register, even while that result waits to be read.
module cubic_bezier_arc_length_sampler_unit import cbals_pkg::*; #(
   parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // param_t[16:0], distance[48:17], subdivisions[59:49], zero above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pos_x[31:0], pos_y[63:32], total_length[95:64]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // past_end[0]
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   cbals_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cbals_dp #(
      .MAX_SUBDIVISIONS (MAX_SUBDIVISIONS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- tb/cubic_bezier_arc_length_sampler_unit_chk.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_bezier_arc_length_sampler_unit_chk
// Watches the request, response and register ports of the Bezier sampler,
// keeps its own copy of the control points, predicts each result and
// compares it field by field with what comes out, in order.
// ---------------------------------------------------------------------------
module cubic_bezier_arc_length_sampler_unit_chk import cbals_pkg::*; #(
   parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_W-1:0]     csr_wdata,
   output int                     errors,
   output int                     pending
);

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] total_length;
      logic        past_end;
   } sample_type;

   longint     ctrl_pt [NUM_LANE][4];
   sample_type samples_due [$];

   function automatic longint floor_div16(longint v);
      if (v >= 0) return v >>> 16;
      return -(((-v) + 65535) >>> 16);
   endfunction

   function automatic longint blend(longint a, longint b, longint f);
      return a + floor_div16((b - a) * f + 32768);
   endfunction

   function automatic longint curve_at(int lane, longint t);
      longint a, b, c, d, e;
      a = blend(ctrl_pt[lane][PT_START], ctrl_pt[lane][PT_GUIDE1], t);
      b = blend(ctrl_pt[lane][PT_GUIDE1], ctrl_pt[lane][PT_GUIDE2], t);
      c = blend(ctrl_pt[lane][PT_GUIDE2], ctrl_pt[lane][PT_FINISH], t);
      d = blend(a, b, t);
      e = blend(b, c, t);
      return blend(d, e, t);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bit_w;
      r = 0;
      bit_w = 64'h4000_0000_0000_0000;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v -= r + bit_w;
            r = (r >> 1) + bit_w;
         end else begin
            r >>= 1;
         end
         bit_w >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned chord_length(longint dx, longint dy);
      longint unsigned ax, ay;
      bit              halved;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      halved = (ax >= 64'h8000_0000) || (ay >= 64'h8000_0000);
      if (halved) begin
         ax >>= 1;
         ay >>= 1;
      end
      return int_sqrt(ax * ax + ay * ay) << halved;
   endfunction

   function automatic sample_type predict_sample(logic op, logic [16:0] t_in,
                                                 logic [31:0] span_in,
                                                 logic [10:0] n_in);
      sample_type             s;
      longint                 px, py, ax, ay, bx, by, t, f;
      longint unsigned        total, prev, len, span, n;
      bit                     hit;
      total = 0;
      hit = 0;
      s.past_end = 1'b0;
      if (op == OP_PARAM) begin
         t = (t_in > T_ONE) ? T_ONE : t_in;
         px = curve_at(0, t);
         py = curve_at(1, t);
      end else begin
         span = span_in;
         n = (n_in == 0) ? 1 : n_in;
         if (n > MAX_SUBDIVISIONS) n = MAX_SUBDIVISIONS;
         px = ctrl_pt[0][PT_FINISH];
         py = ctrl_pt[1][PT_FINISH];
         ax = curve_at(0, 0);
         ay = curve_at(1, 0);
         for (longint unsigned i = 0; i < n; i++) begin
            t = ((i + 1) * 65536) / n;
            bx = curve_at(0, t);
            by = curve_at(1, t);
            len = chord_length(bx - ax, by - ay);
            prev = total;
            total += len;
            if (!hit && span <= total) begin
               f = (len != 0) ? longint'(((span - prev) << 16) / len) : 0;
               px = blend(ax, bx, f);
               py = blend(ay, by, f);
               hit = 1;
            end
            ax = bx;
            ay = by;
         end
         s.past_end = !hit;
         if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      end
      s.pos_x = px[31:0];
      s.pos_y = py[31:0];
      s.total_length = total[31:0];
      return s;
   endfunction

   always @(posedge clock) begin
      sample_type want, got;
      if (reset) begin
         foreach (ctrl_pt[l, p]) ctrl_pt[l][p] = 0;
         samples_due.delete();
         errors = 0;
      end else begin
         if (csr_we)
            ctrl_pt[csr_index % NUM_LANE][csr_index / NUM_LANE] =
               longint'(signed'(csr_wdata));
         if (req_tvalid && req_tready)
            samples_due = {samples_due,
                           predict_sample(req_tuser, req_tdata[16:0],
                                          req_tdata[48:17], req_tdata[59:49])};
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser};
            if (samples_due.size() == 0) begin
               $error("unexpected response word %h", rsp_tdata);
               errors++;
            end else begin
               want = samples_due.pop_front();
               if (got.pos_x !== want.pos_x) begin
                  $error("pos_x expected %h got %h", want.pos_x, got.pos_x);
                  errors++;
               end
               if (got.pos_y !== want.pos_y) begin
                  $error("pos_y expected %h got %h", want.pos_y, got.pos_y);
                  errors++;
               end
               if (got.total_length !== want.total_length) begin
                  $error("total_length expected %h got %h",
                         want.total_length, got.total_length);
                  errors++;
               end
               if (got.past_end !== want.past_end) begin
                  $error("past_end expected %b got %b", want.past_end, got.past_end);
                  errors++;
               end
            end
         end
      end
      pending = samples_due.size();
   end

endmodule

// ----- tb/cubic_bezier_arc_length_sampler_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_bezier_arc_length_sampler_unit_tb
// Drives directed and random requests through the Bezier sampler over
// several control point sets, with random gaps and back pressure, and gives
// the verdict from the checker's error and pending counts.
// ---------------------------------------------------------------------------
module cubic_bezier_arc_length_sampler_unit_tb import cbals_pkg::*;;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 3000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [COORD_W-1:0]     csr_wdata;
   int                     errors;
   int                     pending;
   int                     words_sent;
   int                     words_back;
   int                     cycles;
   bit                     steady;

   cubic_bezier_arc_length_sampler_unit uut (.*);
   cubic_bezier_arc_length_sampler_unit_chk chk (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      if (reset) begin
         words_sent <= 0;
         words_back <= 0;
      end else begin
         if (req_tvalid && req_tready) words_sent <= words_sent + 1;
         if (rsp_tvalid && rsp_tready) words_back <= words_back + 1;
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAIL cubic_bezier_arc_length_sampler_unit");
            $finish;
         end
      end
   end

   // response side: random stalls, one long hold-off
   initial begin
      bit held;
      held = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && words_back == 30) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
         end
      end
   end

   task automatic send_word(logic op, logic [16:0] t, logic [31:0] span,
                            logic [10:0] n);
      bit ok;
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, n, span, t};
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
   endtask

   // step past the accept edge first so the count of the last accepted word has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_back != words_sent) @(posedge clock);
   endtask

   task automatic drain();
      wait_idle();
      repeat (20) @(posedge clock);
   endtask

   task automatic load_curve(logic [31:0] pts [8]);
      for (int i = 0; i < NUM_CSR; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= pts[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random();
      logic [10:0] n;
      logic [31:0] span;
      logic [16:0] t;
      int          pick;
      pick = $urandom_range(0, 99);
      n = (pick < 90) ? 11'($urandom_range(0, 12)) :
          (pick < 98) ? 11'($urandom_range(13, 64)) : 11'($urandom_range(0, 2047));
      span = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 26));
      t = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, T_ONE));
      send_word($urandom_range(0, 1) ? OP_DIST : OP_PARAM, t, span, n);
   endtask

   initial begin
      logic [31:0] pts [8];
      reset = 1'b1;
      steady = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all points at the origin: zero-length chords
      send_word(OP_PARAM, 17'd32768, 32'd0, 11'd1);
      send_word(OP_DIST, 17'd0, 32'd0, 11'd4);
      send_word(OP_DIST, 17'd0, 32'd5, 11'd2);
      drain();

      pts = '{32'd0, 32'd0, 32'd10 << 16, 32'd20 << 16,
              32'd30 << 16, 32'd20 << 16, 32'd40 << 16, 32'd0};
      load_curve(pts);
      send_word(OP_PARAM, 17'd0, 32'd0, 11'd0);
      send_word(OP_PARAM, T_ONE, 32'd0, 11'd0);
      send_word(OP_PARAM, 17'h1FFFF, 32'hFFFF_FFFF, 11'h7FF);
      send_word(OP_PARAM, 17'd21845, 32'd0, 11'd0);
      send_word(OP_DIST, 17'd0, 32'd0, 11'd8);
      send_word(OP_DIST, 17'd0, 32'hFFFF_FFFF, 11'd8);
      send_word(OP_DIST, 17'd0, 32'd20 << 16, 11'd0);
      send_word(OP_DIST, 17'h1FFFF, 32'd25 << 16, 11'h7FF);
      send_word(OP_DIST, 17'd0, 32'd30 << 16, 11'd1024);
      send_word(OP_DIST, 17'd0, 32'd40 << 16, 11'd1);
      send_word(OP_DIST, 17'd0, 32'd1, 11'd3);
      drain();

      // extreme corners: halved chords and saturated length
      pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      load_curve(pts);
      send_word(OP_PARAM, 17'd0, 32'd0, 11'd0);
      send_word(OP_PARAM, 17'd49152, 32'd0, 11'd0);
      send_word(OP_PARAM, T_ONE, 32'd0, 11'd0);
      send_word(OP_DIST, 17'd0, 32'hFFFF_FFFF, 11'd2);
      send_word(OP_DIST, 17'd0, 32'h8000_0000, 11'd5);
      send_word(OP_DIST, 17'd0, 32'd0, 11'd1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         foreach (pts[i])
            pts[i] = (phase == 3) ? 32'($urandom) :
                     32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
         load_curve(pts);
         for (int k = 0; k < 25; k++) begin
            steady = (phase == 1 && k >= 5 && k < 20);
            send_random();
            if (phase == 2 && k == 12) begin
               wait_idle();
            end
         end
         steady = 0;
         drain();
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("PASS cubic_bezier_arc_length_sampler_unit");
      end else begin
         $display("FAIL cubic_bezier_arc_length_sampler_unit");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cbals_pkg.sv
rtl/cbals_div.sv
rtl/cbals_sqrt.sv
rtl/cbals_dp.sv
rtl/cbals_ctrl.sv
rtl/cubic_bezier_arc_length_sampler_unit.sv
tb/cubic_bezier_arc_length_sampler_unit_chk.sv
tb/cubic_bezier_arc_length_sampler_unit_tb.sv
